[src/i2cbm_pkg.sv]
// Package for the I2C bit-level master: command codes, phase counts and the
// pin/shift bundle that passes between the top level and the phase decoder.
// No dependencies.
package i2cbm_pkg;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   localparam int DELAY_BITS_DEFAULT = 16;
   localparam int HALF_PERIOD_BITS = 16;
   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 16'd500;

   localparam int PHASE_BITS = 5;
   localparam logic [PHASE_BITS-1:0] START_PHASES = 5'd3;
   localparam logic [PHASE_BITS-1:0] STOP_PHASES  = 5'd2;
   localparam logic [PHASE_BITS-1:0] BYTE_PHASES  = 5'd18;
   localparam logic [PHASE_BITS-1:0] ACK_PHASE    = 5'd16;

   // Pin drives and the byte shift register, updated on entry to a phase.
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] shift;
   } pin_state_type;

   function automatic logic [PHASE_BITS-1:0] phase_total(input cmd_type cmd);
      logic [PHASE_BITS-1:0] total;
      unique case (cmd)
         CMD_START: total = START_PHASES;
         CMD_STOP:  total = STOP_PHASES;
         default:   total = BYTE_PHASES;
      endcase
      return total;
   endfunction

endpackage

[src/i2cbm_phase.sv]
// Phase entry decoder for the I2C bit-level master: sets the clock and data
// drives, and shifts the write byte, for a given command and phase.
// Depends on i2cbm_pkg.
module i2cbm_phase
   import i2cbm_pkg::*;
(
   input  cmd_type               cmd,
   input  logic [PHASE_BITS-1:0] phase,
   input  logic                  ack_request,
   input  pin_state_type         cur,
   output pin_state_type         nxt
);

   always_comb begin
      nxt = cur;
      unique case (cmd)
         CMD_START: begin
            if (phase == '0) begin
               nxt.scl = 1'b1;
               nxt.sda = 1'b1;
            end else if (phase == PHASE_BITS'(1)) begin
               nxt.sda = 1'b0;
            end else begin
               nxt.scl = 1'b0;
            end
         end
         CMD_STOP: begin
            if (phase == '0) begin
               nxt.sda = 1'b0;
               nxt.scl = 1'b1;
            end else begin
               nxt.sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (phase < ACK_PHASE) begin
               if (!phase[0]) begin
                  nxt.sda   = cur.shift[7];
                  nxt.shift = {cur.shift[6:0], 1'b0};
                  nxt.scl   = 1'b1;
               end else begin
                  nxt.scl = 1'b0;
               end
            end else if (phase == ACK_PHASE) begin
               nxt.sda = 1'b1;
               nxt.scl = 1'b1;
            end else begin
               nxt.scl = 1'b0;
            end
         end
         CMD_READ: begin
            if (phase == '0) begin
               nxt.sda = 1'b1;
            end
            if (phase < ACK_PHASE) begin
               nxt.scl = ~phase[0];
            end else if (phase == ACK_PHASE) begin
               nxt.sda = ~ack_request;
               nxt.scl = 1'b1;
            end else begin
               nxt.scl = 1'b0;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

[src/i2c_bit_level_master.sv]
// Top level of the I2C bit-level master: command and tick sequencer with a
// registered result stage. Depends on i2cbm_pkg and i2cbm_phase.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  opcode, data byte, ack select, sda
//   rsp_     out        rsp_valid/rsp_stall  pin drives, busy, done, ack, byte
//   csr_     in         csr_write_enable     half period in ticks
//
// The sequencer state and the result register are both updated at the edge
// that accepts a request, so a request can be taken in every cycle while
// req_stall is low. A request is taken while a result waits, as long as that
// result is taken in the same cycle. Reset is synchronous and returns the
// sequencer to idle with both lines released and the half period at 500.
// While rsp_stall holds a waiting result, req_stall is high.
module i2c_bit_level_master
   import i2cbm_pkg::*;
#(
   parameter int DELAY_BITS = DELAY_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [HALF_PERIOD_BITS-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_opcode,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_send_ack,
   input  logic                        req_sda_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic                        rsp_ack_level,
   output logic [7:0]                  rsp_read_byte,
   output logic                        rsp_rejected
);

   localparam logic [31:0] DELAY_CAP = 32'hFFFF_FFFF >> (32 - DELAY_BITS);

   logic [HALF_PERIOD_BITS-1:0] half_period_ff;

   cmd_type               cmd_ff, cmd_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   pin_state_type         pins_ff, pins_in;
   logic                  ack_request_ff, ack_request_in;
   logic                  ack_sampled_ff, ack_sampled_in;

   logic       rsp_valid_ff;
   logic       done_ff, done_in;
   logic       rejected_ff, rejected_in;
   logic [7:0] read_byte_ff, read_byte_in;

   logic                  accept;
   logic                  is_cmd;
   logic [31:0]           len_wide;
   logic [DELAY_BITS-1:0] phase_len;
   logic [PHASE_BITS-1:0] phase_next;

   cmd_type               dec_cmd;
   logic [PHASE_BITS-1:0] dec_phase;
   logic                  dec_enter;
   pin_state_type         dec_cur;
   pin_state_type         dec_nxt;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_cmd    = (req_opcode != 3'(CMD_IDLE)) && (req_opcode <= 3'(CMD_READ));

   // A zero half period counts as one tick; a long one saturates the counter.
   always_comb begin
      len_wide = {16'b0, half_period_ff};
      if (len_wide == '0) begin
         len_wide = 32'd1;
      end
      if (len_wide > DELAY_CAP) begin
         len_wide = DELAY_CAP;
      end
      phase_len = len_wide[DELAY_BITS-1:0];
   end

   assign phase_next = phase_ff + PHASE_BITS'(1);

   i2cbm_phase u_phase (
      .cmd         (dec_cmd),
      .phase       (dec_phase),
      .ack_request (ack_request_in),
      .cur         (dec_cur),
      .nxt         (dec_nxt)
   );

   always_comb begin
      cmd_in         = cmd_ff;
      phase_in       = phase_ff;
      delay_in       = delay_ff;
      pins_in        = pins_ff;
      ack_request_in = ack_request_ff;
      ack_sampled_in = ack_sampled_ff;
      done_in        = 1'b0;
      rejected_in    = 1'b0;
      read_byte_in   = 8'd0;
      dec_cmd        = cmd_ff;
      dec_phase      = phase_next;
      dec_cur        = pins_ff;
      dec_enter      = 1'b0;

      if (cmd_ff == CMD_IDLE) begin
         if (is_cmd) begin
            cmd_in    = cmd_type'(req_opcode);
            phase_in  = '0;
            dec_cmd   = cmd_type'(req_opcode);
            dec_phase = '0;
            dec_enter = 1'b1;
            if (cmd_type'(req_opcode) == CMD_WRITE) begin
               dec_cur.shift = req_data_byte;
            end else if (cmd_type'(req_opcode) == CMD_READ) begin
               dec_cur.shift  = 8'd0;
               ack_request_in = req_send_ack;
            end
         end
      end else begin
         rejected_in = is_cmd;
         if (delay_ff > DELAY_BITS'(1)) begin
            delay_in = delay_ff - DELAY_BITS'(1);
         end else begin
            if (cmd_ff == CMD_WRITE && phase_ff == ACK_PHASE) begin
               ack_sampled_in = req_sda_in;
            end
            if (cmd_ff == CMD_READ && phase_ff < ACK_PHASE && !phase_ff[0]) begin
               dec_cur.shift = {pins_ff.shift[6:0], req_sda_in};
            end
            if (phase_next >= phase_total(cmd_ff)) begin
               done_in       = 1'b1;
               pins_in.shift = dec_cur.shift;
               if (cmd_ff == CMD_READ) begin
                  pins_in.sda  = 1'b1;
                  read_byte_in = dec_cur.shift;
               end
               cmd_in   = CMD_IDLE;
               phase_in = '0;
               delay_in = '0;
            end else begin
               phase_in  = phase_next;
               dec_enter = 1'b1;
            end
         end
      end

      if (dec_enter) begin
         pins_in  = dec_nxt;
         delay_in = phase_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_write_enable) begin
         half_period_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff         <= CMD_IDLE;
         phase_ff       <= '0;
         delay_ff       <= '0;
         pins_ff        <= '{scl: 1'b1, sda: 1'b1, shift: 8'd0};
         ack_request_ff <= 1'b0;
         ack_sampled_ff <= 1'b0;
      end else if (accept) begin
         cmd_ff         <= cmd_in;
         phase_ff       <= phase_in;
         delay_ff       <= delay_in;
         pins_ff        <= pins_in;
         ack_request_ff <= ack_request_in;
         ack_sampled_ff <= ack_sampled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The result mirrors the sequencer state right after the request.
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff      <= done_in;
         rejected_ff  <= rejected_in;
         read_byte_ff <= read_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = pins_ff.scl;
   assign rsp_sda_level = pins_ff.sda;
   assign rsp_busy_res  = (cmd_ff != CMD_IDLE);
   assign rsp_done_res  = done_ff;
   assign rsp_ack_level = ack_sampled_ff;
   assign rsp_read_byte = read_byte_ff;
   assign rsp_rejected  = rejected_ff;

   // Since the sequencer only moves on an accepted request, its registers
   // stay in step with the waiting result while the output is stalled.

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(done_ff && cmd_ff != CMD_IDLE))
      else $error("done reported while a command is still in progress");

   a_idle_no_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_ff == CMD_IDLE) |=> !rejected_ff)
      else $error("request rejected although the sequencer was idle");

   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_IDLE) |-> (phase_ff == '0 && delay_ff == '0))
      else $error("idle sequencer holds a phase or delay count");

   a_read_byte_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (read_byte_ff == 8'd0))
      else $error("read byte shown on a request that did not finish a read");

endmodule

[sim/tb_i2c_bit_level_master.sv]
// Self-checking testbench for the I2C bit-level master pin sequencer.
// Drives requests through a stall handshake, predicts every pin result in
// SystemVerilog and compares each result field. Depends on i2cbm_pkg.
module tb_i2c_bit_level_master
   import i2cbm_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int LIMIT_CYCLES   = 100_000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_REQUESTS = 295;
   localparam int RANDOM_PHASES  = 6;
   localparam int FINAL_TICKS    = 64;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic       ack;
      logic [7:0] read_byte;
      logic       rejected;
   } line_state_type;

   typedef struct packed {
      logic           is_cfg;
      logic [15:0]    cfg_value;
      req_item_type   req;
      logic [15:0]    count;
      logic           typed;
      line_state_type want;
   } plan_row_type;

   localparam line_state_type RELEASED_IDLE =
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam line_state_type START_ENTERED =
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam line_state_type START_REJECT =
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};
   localparam line_state_type NO_WANT = '0;

   localparam int DIRECTED_ROWS = 18;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b0}, 16'd1,  1'b1, RELEASED_IDLE},
      '{1'b0, 16'd0, '{OP_SPARE_7, 8'hFF, 1'b1, 1'b1}, 16'd1,  1'b1, RELEASED_IDLE},
      '{1'b0, 16'd0, '{OP_SPARE_5, 8'h5A, 1'b0, 1'b1}, 16'd1,  1'b1, RELEASED_IDLE},
      '{1'b1, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b0}, 16'd0,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_START,  8'h00, 1'b0, 1'b0}, 16'd1,  1'b1, START_ENTERED},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b1}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_WRITE,  8'hFF, 1'b1, 1'b1}, 16'd1,  1'b1, START_REJECT},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b0}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_STOP,   8'h00, 1'b0, 1'b0}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_READ,   8'h00, 1'b1, 1'b0}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b1}, 16'd1,  1'b0, NO_WANT},
      '{1'b1, 16'd1, '{OP_TICK,    8'h00, 1'b0, 1'b0}, 16'd0,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_WRITE,  8'hFF, 1'b0, 1'b1}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b1}, 16'd16, 1'b0, NO_WANT},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b0}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{OP_TICK,    8'h00, 1'b0, 1'b1}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{CMD_READ,   8'h00, 1'b1, 1'b1}, 16'd1,  1'b0, NO_WANT},
      '{1'b0, 16'd0, '{OP_SPARE_6, 8'h00, 1'b0, 1'b1}, 16'd18, 1'b0, NO_WANT}
   };

   localparam logic [15:0] RANDOM_HALF_PERIODS [RANDOM_PHASES] =
      '{16'd1, 16'd0, 16'd2, 16'd3, 16'd1, 16'd4};

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [7:0]  req_data_byte;
   logic        req_send_ack;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ack_level;
   logic [7:0]  rsp_read_byte;
   logic        rsp_rejected;

   // Bit engine mirror.
   cmd_type     eng_cmd;
   logic [4:0]  eng_phase;
   logic [15:0] eng_delay;
   logic [7:0]  eng_shift;
   logic        eng_ack_req;
   logic        eng_ack_seen;
   logic        eng_scl;
   logic        eng_sda;
   logic [15:0] half_period;

   line_state_type pending_line_states [$];

   int errors = 0;
   int cycles = 0;
   int requests = 0;
   int engaged_requests = 0;
   int started_cmds = 0;
   int rejected_cmds = 0;
   int completed_cmds = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   bit no_gaps = 1'b0;

   i2c_bit_level_master i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_send_ack     (req_send_ack),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_level    (rsp_ack_level),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_rejected     (rsp_rejected)
   );

   always #5 clock = ~clock;

   function automatic logic [4:0] phases_of(input cmd_type cmd);
      if (cmd == CMD_START) return START_PHASES;
      if (cmd == CMD_STOP) return STOP_PHASES;
      return BYTE_PHASES;
   endfunction

   // A zero half period counts as one tick. With a 16-bit delay counter the
   // saturation limit equals the largest register value.
   function automatic logic [15:0] phase_ticks();
      return (half_period == 16'd0) ? 16'd1 : half_period;
   endfunction

   task automatic enter_phase(input cmd_type cmd, input logic [4:0] p);
      case (cmd)
         CMD_START: begin
            if (p == 5'd0) begin
               eng_scl = 1'b1;
               eng_sda = 1'b1;
            end else if (p == 5'd1) begin
               eng_sda = 1'b0;
            end else begin
               eng_scl = 1'b0;
            end
         end
         CMD_STOP: begin
            if (p == 5'd0) begin
               eng_sda = 1'b0;
               eng_scl = 1'b1;
            end else begin
               eng_sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (p < ACK_PHASE) begin
               if (!p[0]) begin
                  eng_sda   = eng_shift[7];
                  eng_shift = {eng_shift[6:0], 1'b0};
                  eng_scl   = 1'b1;
               end else begin
                  eng_scl = 1'b0;
               end
            end else if (p == ACK_PHASE) begin
               eng_sda = 1'b1;
               eng_scl = 1'b1;
            end else begin
               eng_scl = 1'b0;
            end
         end
         default: begin
            if (p == 5'd0) eng_sda = 1'b1;
            if (p < ACK_PHASE) begin
               eng_scl = !p[0];
            end else if (p == ACK_PHASE) begin
               eng_sda = !eng_ack_req;
               eng_scl = 1'b1;
            end else begin
               eng_scl = 1'b0;
            end
         end
      endcase
      eng_delay = phase_ticks();
   endtask

   // Advances the mirror by one request and returns the line state after it.
   task automatic advance_bit_engine(input req_item_type r, output line_state_type s,
                                     output logic engaged);
      logic       is_cmd;
      logic [4:0] next_phase;
      is_cmd  = (r.opcode >= CMD_START) && (r.opcode <= CMD_READ);
      engaged = is_cmd || (eng_cmd != CMD_IDLE);
      s = '0;
      if (eng_cmd == CMD_IDLE) begin
         if (is_cmd) begin
            started_cmds++;
            eng_cmd   = cmd_type'(r.opcode);
            eng_phase = 5'd0;
            if (eng_cmd == CMD_WRITE) begin
               eng_shift = r.data_byte;
            end else if (eng_cmd == CMD_READ) begin
               eng_shift   = 8'h00;
               eng_ack_req = r.send_ack;
            end
            enter_phase(eng_cmd, 5'd0);
         end
      end else begin
         // A command while busy is dropped but still counts as a tick.
         if (is_cmd) begin
            s.rejected = 1'b1;
            rejected_cmds++;
         end
         if (eng_delay > 16'd1) begin
            eng_delay--;
         end else begin
            if (eng_cmd == CMD_WRITE && eng_phase == ACK_PHASE) eng_ack_seen = r.sda_in;
            if (eng_cmd == CMD_READ && eng_phase < ACK_PHASE && !eng_phase[0])
               eng_shift = {eng_shift[6:0], r.sda_in};
            next_phase = eng_phase + 5'd1;
            if (next_phase >= phases_of(eng_cmd)) begin
               s.done = 1'b1;
               completed_cmds++;
               if (eng_cmd == CMD_READ) begin
                  eng_sda     = 1'b1;
                  s.read_byte = eng_shift;
               end
               eng_cmd   = CMD_IDLE;
               eng_phase = 5'd0;
               eng_delay = 16'd0;
            end else begin
               eng_phase = next_phase;
               enter_phase(eng_cmd, next_phase);
            end
         end
      end
      s.scl  = eng_scl;
      s.sda  = eng_sda;
      s.busy = (eng_cmd != CMD_IDLE);
      s.ack  = eng_ack_seen;
   endtask

   task automatic send_request(input req_item_type r, input logic typed,
                               input line_state_type want);
      int             gap;
      line_state_type predicted;
      logic           engaged;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (no_gaps || hold_left > 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_opcode    <= r.opcode;
      req_data_byte <= r.data_byte;
      req_send_ack  <= r.send_ack;
      req_sda_in    <= r.sda_in;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      advance_bit_engine(r, predicted, engaged);
      requests++;
      if (engaged) engaged_requests++;
      pending_line_states.push_back(typed ? want : predicted);
   endtask

   task automatic set_half_period(input logic [15:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_line_states.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      half_period = value;
      burst_left  = 0;
   endtask

   // Mostly ticks while a command runs, with some rejected commands and
   // unused opcodes mixed in.
   function automatic req_item_type filler_request();
      req_item_type r;
      int           pick;
      r.data_byte = 8'($urandom);
      r.send_ack  = 1'($urandom);
      r.sda_in    = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) r.opcode = 3'($urandom_range(CMD_START, CMD_READ));
      else if (pick < 9) r.opcode = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      else r.opcode = OP_TICK;
      return r;
   endfunction

   task automatic run_sequence();
      req_item_type r;
      int           pick;
      int           ticks;
      int           k;
      pick = $urandom_range(0, 9);
      if (pick < 2) r.opcode = CMD_START;
      else if (pick < 4) r.opcode = CMD_STOP;
      else if (pick < 7) r.opcode = CMD_WRITE;
      else r.opcode = CMD_READ;
      pick = $urandom_range(0, 7);
      r.data_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      r.send_ack  = 1'($urandom);
      r.sda_in    = 1'($urandom);
      send_request(r, 1'b0, NO_WANT);
      ticks = int'(phases_of(cmd_type'(r.opcode))) * int'(phase_ticks());
      // Now and then the sequence is cut short so the next command collides.
      if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks);
      ticks += $urandom_range(0, 2);
      for (k = 0; k < ticks; k++) send_request(filler_request(), 1'b0, NO_WANT);
   endtask

   initial begin : receiver
      int mode_left;
      int mode;
      mode_left = 0;
      mode      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 60);
               mode      = $urandom_range(0, 2);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 4) == 0);
               default: rsp_stall <= 1'($urandom);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      line_state_type seen;
      line_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res,
                  rsp_ack_level, rsp_read_byte, rsp_rejected};
         if (pending_line_states.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result with nothing expected: scl %b sda %b busy %b",
                        seen.scl, seen.sda, seen.busy);
         end else begin
            want = pending_line_states.pop_front();
            if (seen !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"ERROR: scl %b/%b sda %b/%b busy %b/%b done %b/%b ",
                            "ack %b/%b byte %h/%h rej %b/%b (expected/actual)"},
                           want.scl, seen.scl, want.sda, seen.sda,
                           want.busy, seen.busy, want.done, seen.done,
                           want.ack, seen.ack, want.read_byte, seen.read_byte,
                           want.rejected, seen.rejected);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycles);
         $display("FAIL i2c_bit_level_master");
         $finish;
      end
   end

   initial begin : stimulus
      int           row;
      int           k;
      int           p;
      req_item_type r;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 16'd0;
      req_valid        = 1'b0;
      req_opcode       = OP_TICK;
      req_data_byte    = 8'h00;
      req_send_ack     = 1'b0;
      req_sda_in       = 1'b0;
      eng_cmd      = CMD_IDLE;
      eng_phase    = 5'd0;
      eng_delay    = 16'd0;
      eng_shift    = 8'h00;
      eng_ack_req  = 1'b0;
      eng_ack_seen = 1'b0;
      eng_scl      = 1'b1;
      eng_sda      = 1'b1;
      half_period  = HALF_PERIOD_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED_PLAN[row].is_cfg) begin
            set_half_period(DIRECTED_PLAN[row].cfg_value);
         end else begin
            for (k = 0; k < int'(DIRECTED_PLAN[row].count); k++)
               send_request(DIRECTED_PLAN[row].req, DIRECTED_PLAN[row].typed,
                            DIRECTED_PLAN[row].want);
         end
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_half_period(RANDOM_HALF_PERIODS[p]);
         // The long receiver hold-off lands early in the first random phase.
         if (p == 0) hold_request = 1'b1;
         k = requests;
         while (requests - k < PHASE_REQUESTS) run_sequence();
      end

      // Largest half period: a stop condition entered at full phase length
      // and counted down for a short run of ticks, sent without sender gaps.
      set_half_period(16'hFFFF);
      no_gaps = 1'b1;
      r = '{CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom)};
      send_request(r, 1'b0, NO_WANT);
      for (k = 0; k < FINAL_TICKS; k++) send_request(filler_request(), 1'b0, NO_WANT);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_line_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_line_states.size() != 0) begin
         errors++;
         $display("ERROR: %0d results never arrived", pending_line_states.size());
      end

      $display("Run covered %0d requests (%0d with a command active): %0d started, %0d rejected, %0d done.",
               requests, engaged_requests, started_cmds, rejected_cmds, completed_cmds);
      $display("Half periods 500, 0 to 4 and 65535; one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("PASS i2c_bit_level_master");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL i2c_bit_level_master");
      end
      $finish;
   end

endmodule

[filelist.f]
src/i2cbm_pkg.sv
src/i2cbm_phase.sv
src/i2c_bit_level_master.sv
sim/tb_i2c_bit_level_master.sv
